### design/mdfs_pkg.sv
// ============================================================================
// mdfs_pkg: shared types and constants for the depth-first maze explorer
// Grid and stack sizes, heading codes, command and status words between the
// controller and the datapath, and the neighbour and cell-index helpers.
// ============================================================================
`default_nettype none

package mdfs_pkg;

  // Grid and stack sizing
  localparam int GRID_SIZE   = 16;
  localparam int STACK_DEPTH = 256;
  localparam int COORD_W     = 4;
  localparam int CELLS       = GRID_SIZE * GRID_SIZE;
  localparam int CELL_W      = $clog2(CELLS);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int FRAME_W     = 9;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         dir_t;

  localparam coord_t GRID_MAX = coord_t'(GRID_SIZE - 1);

  // Absolute headings: x grows right, y grows down
  localparam dir_t DIR_RIGHT = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_UP    = 2'd3;

  // Input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ACT_MARK   = 2'd0,
    ACT_TURN   = 2'd1,
    ACT_MOVE   = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PK_IDLE    = 2'd0,
    PK_EXPLORE = 2'd1,
    PK_BACK    = 2'd2,
    PK_DONE    = 2'd3
  } pend_t;

  // Where a new turn target comes from
  typedef enum logic [1:0] {
    TGT_BACK  = 2'd0,  // reverse of current heading
    TGT_CAND  = 2'd1,  // direction under test in top frame
    TGT_ENTRY = 2'd2   // reverse of top frame entry direction
  } tgt_sel_t;

  // One stack frame
  typedef struct packed {
    dir_t       entry;
    logic [2:0] try_dir;  // 0..3 still to try, 4 when exhausted
    logic [3:0] walls;    // absolute wall bits
  } frame_t;

  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } nbr_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     restart;
    logic     advance;
    logic     mark;
    logic     push;
    logic     try_inc;
    logic     pop;
    logic     set_tgt;
    tgt_sel_t tgt_sel;
    logic     turn;
    logic     set_pk;
    pend_t    pk;
    logic     emit;
    action_t  act;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  cmd;
    logic  move_ok;
    pend_t pk;
    logic  seen;
    logic  full;
    logic  sp_zero;
    logic  sp_one;
    logic  scan_done;
    logic  cand_ok;
    logic  at_target;
  } dp_stat_t;

  // Neighbour cell in a direction; ok is low when it falls off the grid
  function automatic nbr_t neighbour(coord_t x, coord_t y, dir_t d);
    nbr_t n;
    n.ok = 1'b1;
    n.x  = x;
    n.y  = y;
    case (d)
      DIR_RIGHT: begin
        n.ok = (x != GRID_MAX);
        n.x  = x + coord_t'(1);
      end
      DIR_DOWN: begin
        n.ok = (y != GRID_MAX);
        n.y  = y + coord_t'(1);
      end
      DIR_LEFT: begin
        n.ok = (x != '0);
        n.x  = x - coord_t'(1);
      end
      DIR_UP: begin
        n.ok = (y != '0);
        n.y  = y - coord_t'(1);
      end
      default: n.ok = 1'b0;
    endcase
    return n;
  endfunction

  // Row-major cell index
  function automatic logic [CELL_W-1:0] cell_index(coord_t x, coord_t y);
    return CELL_W'(y) * CELL_W'(GRID_SIZE) + CELL_W'(x);
  endfunction

endpackage

`default_nettype wire

### design/mdfs_ram.sv
// ============================================================================
// mdfs_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module mdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/mdfs_ctrl.sv
// ============================================================================
// mdfs_ctrl: explorer sequencer
// Walks one input word through dispatch, arrival, direction scan and turns,
// issuing one datapath command word per cycle and the result words it calls for.
// ============================================================================
`default_nettype none

module mdfs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mdfs_pkg::dp_stat_t  stat,
  output mdfs_pkg::ctl_cmd_t       cmd
);

  import mdfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ARRIVE,
    S_EXPLORE,
    S_TURN
  } state_t;

  // What follows once the heading reaches the target
  typedef enum logic [1:0] {
    AFT_SCAN,
    AFT_EXPLORE_MOVE,
    AFT_BACK_MOVE
  } after_t;

  state_t state_r, state_nxt;
  after_t after_r, after_nxt;
  logic   busy_r;

  assign busy = busy_r;

  // Next state and command word
  always_comb begin
    state_nxt   = state_r;
    after_nxt   = after_r;
    cmd         = '0;
    cmd.tgt_sel = TGT_BACK;
    cmd.pk      = PK_IDLE;
    cmd.act     = ACT_MARK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.cmd == CMD_START) begin
          cmd.restart = 1'b1;
          state_nxt   = S_ARRIVE;
        end else begin
          case (stat.pk)
            PK_EXPLORE: begin
              if (stat.move_ok) begin
                cmd.advance = 1'b1;
                state_nxt   = S_ARRIVE;
              end else begin
                state_nxt = S_EXPLORE;
              end
            end
            PK_BACK: begin
              // back at the parent: face the way we left, then rescan
              cmd.advance = 1'b1;
              cmd.set_tgt = 1'b1;
              cmd.tgt_sel = TGT_BACK;
              after_nxt   = AFT_SCAN;
              state_nxt   = S_TURN;
            end
            PK_DONE: begin
              cmd.emit  = 1'b1;
              cmd.act   = ACT_FINISH;
              state_nxt = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ARRIVE: begin
        cmd.mark = 1'b1;
        cmd.emit = 1'b1;
        cmd.act  = ACT_MARK;
        if (stat.seen || stat.full) begin
          // dead arrival: turn around and step straight back
          cmd.set_tgt = 1'b1;
          cmd.tgt_sel = TGT_BACK;
          after_nxt   = AFT_BACK_MOVE;
          state_nxt   = S_TURN;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_EXPLORE;
        end
      end
      S_EXPLORE: begin
        if (stat.sp_zero) begin
          cmd.emit   = 1'b1;
          cmd.act    = ACT_FINISH;
          cmd.set_pk = 1'b1;
          cmd.pk     = PK_DONE;
          state_nxt  = S_IDLE;
        end else if (!stat.scan_done) begin
          // one candidate direction per cycle
          cmd.try_inc = 1'b1;
          if (stat.cand_ok) begin
            cmd.set_tgt = 1'b1;
            cmd.tgt_sel = TGT_CAND;
            after_nxt   = AFT_EXPLORE_MOVE;
            state_nxt   = S_TURN;
          end
        end else if (stat.sp_one) begin
          cmd.emit   = 1'b1;
          cmd.act    = ACT_FINISH;
          cmd.set_pk = 1'b1;
          cmd.pk     = PK_DONE;
          state_nxt  = S_IDLE;
        end else begin
          // cell exhausted: pop and head back to the parent
          cmd.pop     = 1'b1;
          cmd.set_tgt = 1'b1;
          cmd.tgt_sel = TGT_ENTRY;
          after_nxt   = AFT_BACK_MOVE;
          state_nxt   = S_TURN;
        end
      end
      S_TURN: begin
        if (!stat.at_target) begin
          cmd.turn = 1'b1;
          cmd.emit = 1'b1;
          cmd.act  = ACT_TURN;
        end else begin
          case (after_r)
            AFT_SCAN: state_nxt = S_EXPLORE;
            AFT_EXPLORE_MOVE: begin
              cmd.emit   = 1'b1;
              cmd.act    = ACT_MOVE;
              cmd.set_pk = 1'b1;
              cmd.pk     = PK_EXPLORE;
              state_nxt  = S_IDLE;
            end
            AFT_BACK_MOVE: begin
              cmd.emit   = 1'b1;
              cmd.act    = ACT_MOVE;
              cmd.set_pk = 1'b1;
              cmd.pk     = PK_BACK;
              state_nxt  = S_IDLE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= AFT_SCAN;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

`default_nettype wire

### design/mdfs_dp.sv
// ============================================================================
// mdfs_dp: explorer datapath
// Position, heading, visited map, frame stack with a cached top frame, turn
// target and the registered result word.
// ============================================================================
`default_nettype none

module mdfs_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mdfs_pkg::ctl_cmd_t       cmd,
  output mdfs_pkg::dp_stat_t            stat,
  input  wire logic                     in_command,
  input  wire logic                     in_move_ok,
  input  wire logic                     in_wall_front,
  input  wire logic                     in_wall_right,
  input  wire logic                     in_wall_left,
  output logic                          out_valid,
  output logic [1:0]                    out_action,
  output logic [mdfs_pkg::COORD_W-1:0]  out_cell_x,
  output logic [mdfs_pkg::COORD_W-1:0]  out_cell_y,
  output logic                          out_last
);

  import mdfs_pkg::*;

  // Captured input word
  logic cmd_r, ok_r, wf_r, wr_r, wl_r;

  // Exploration state
  coord_t          pos_x_r, pos_y_r;
  dir_t            heading_r, target_r;
  logic [CELLS-1:0] visited_r;
  logic [SP_W-1:0] sp_r;
  pend_t           pk_r;
  frame_t          top_r;
  logic            fill_r;

  // Result register
  logic            out_valid_r;
  action_t         out_action_r;
  coord_t          out_x_r, out_y_r;
  logic            out_last_r;

  // Frame memory port signals
  logic [SP_W-1:0] sp_m1, sp_m2;
  logic            ram_we;
  frame_t          ram_rdata;

  nbr_t              nb_head, nb_cand;
  logic [CELL_W-1:0] cur_idx, cand_idx;
  dir_t              cand_dir;
  logic [3:0]        walls_new;

  // Neighbours and lookups
  assign cand_dir = top_r.try_dir[1:0];
  assign nb_head  = neighbour(pos_x_r, pos_y_r, heading_r);
  assign nb_cand  = neighbour(pos_x_r, pos_y_r, cand_dir);
  assign cur_idx  = cell_index(pos_x_r, pos_y_r);
  assign cand_idx = cell_index(nb_cand.x, nb_cand.y);

  // Sensor walls rotated to absolute directions; rear left open
  always_comb begin
    walls_new = '0;
    if (wf_r) walls_new[heading_r] = 1'b1;
    if (wr_r) walls_new[heading_r + 2'd1] = 1'b1;
    if (wl_r) walls_new[heading_r + 2'd3] = 1'b1;
  end

  // Status back to the controller
  always_comb begin
    stat.cmd       = cmd_r;
    stat.move_ok   = ok_r;
    stat.pk        = pk_r;
    stat.seen      = visited_r[cur_idx];
    stat.full      = (sp_r >= SP_W'(STACK_DEPTH));
    stat.sp_zero   = (sp_r == '0);
    stat.sp_one    = (sp_r == SP_W'(1));
    stat.scan_done = top_r.try_dir[2];
    stat.cand_ok   = !top_r.walls[cand_dir] && nb_cand.ok && !visited_r[cand_idx];
    stat.at_target = (heading_r == target_r);
  end

  // Frame memory: entries below the top live here, the top lives in top_r
  assign sp_m1  = sp_r - SP_W'(1);
  assign sp_m2  = sp_r - SP_W'(2);
  assign ram_we = cmd.push && (sp_r != '0);

  mdfs_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STACK_DEPTH)
  ) u_frames (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_m1[SA_W-1:0]),
    .wdata (top_r),
    .raddr (sp_m2[SA_W-1:0]),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= DIR_RIGHT;
      visited_r   <= '0;
      sp_r        <= '0;
      pk_r        <= PK_IDLE;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= cmd.pop;
      out_valid_r <= cmd.emit;
      if (cmd.restart) begin
        pos_x_r   <= '0;
        pos_y_r   <= '0;
        heading_r <= DIR_RIGHT;
        visited_r <= '0;
        sp_r      <= '0;
        pk_r      <= PK_IDLE;
      end else begin
        if (cmd.advance && nb_head.ok) begin
          pos_x_r <= nb_head.x;
          pos_y_r <= nb_head.y;
        end
        if (cmd.turn) heading_r <= heading_r + 2'd1;
        if (cmd.mark) visited_r[cur_idx] <= 1'b1;
        if (cmd.push) begin
          sp_r <= sp_r + SP_W'(1);
        end else if (cmd.pop) begin
          sp_r <= sp_m1;
        end
        if (cmd.set_pk) pk_r <= cmd.pk;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      ok_r  <= in_move_ok;
      wf_r  <= in_wall_front;
      wr_r  <= in_wall_right;
      wl_r  <= in_wall_left;
    end
    // top frame: fresh push, scan step, or reload after a pop
    if (cmd.push) begin
      top_r.entry   <= heading_r;
      top_r.try_dir <= '0;
      top_r.walls   <= walls_new;
    end else if (cmd.try_inc) begin
      top_r.try_dir <= top_r.try_dir + 3'd1;
    end else if (fill_r) begin
      top_r <= ram_rdata;
    end
    if (cmd.set_tgt) begin
      case (cmd.tgt_sel)
        TGT_BACK:  target_r <= heading_r + 2'd2;
        TGT_CAND:  target_r <= cand_dir;
        TGT_ENTRY: target_r <= top_r.entry + 2'd2;
        default:   target_r <= heading_r;
      endcase
    end
    if (cmd.emit) begin
      out_action_r <= cmd.act;
      out_x_r      <= pos_x_r;
      out_y_r      <= pos_y_r;
      out_last_r   <= (cmd.act == ACT_MOVE) || (cmd.act == ACT_FINISH);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_cell_x = out_x_r;
  assign out_cell_y = out_y_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### design/maze_dfs_explorer.sv
// ============================================================================
// maze_dfs_explorer: depth-first maze explorer, top level
// Sequencer and datapath; issues mark, turn-right, move and finished words.
// ============================================================================
// Results: once an input word is taken, result words follow at most one
//   per cycle; busy stays high while the word is being worked on.
// Throughput: one input word at a time, set by the direction scan (one
//   candidate per cycle) and by one right turn per cycle.
// Reset: synchronous, active low; clears position, heading, visited map, stack
//   depth and pending kind. Frame memory not cleared; receiver cannot stall.
`default_nettype none

module maze_dfs_explorer (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_command,
  input  wire logic                    in_move_ok,
  input  wire logic                    in_wall_front,
  input  wire logic                    in_wall_right,
  input  wire logic                    in_wall_left,
  output logic                         out_valid,
  output logic [1:0]                   out_action,
  output logic [mdfs_pkg::COORD_W-1:0] out_cell_x,
  output logic [mdfs_pkg::COORD_W-1:0] out_cell_y,
  output logic                         out_last
);

  import mdfs_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mdfs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mdfs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_command    (in_command),
    .in_move_ok    (in_move_ok),
    .in_wall_front (in_wall_front),
    .in_wall_right (in_wall_right),
    .in_wall_left  (in_wall_left),
    .out_valid     (out_valid),
    .out_action    (out_action),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

### design/mdfs_checker.sv
// ============================================================================
// mdfs_checker: port-level checks for the maze explorer
// Watches the top-level ports only; bound to every explorer instance.
// ============================================================================
`default_nettype none

module mdfs_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    in_command,
  input wire logic                    in_move_ok,
  input wire logic                    in_wall_front,
  input wire logic                    in_wall_right,
  input wire logic                    in_wall_left,
  input wire logic                    out_valid,
  input wire logic [1:0]              out_action,
  input wire logic [mdfs_pkg::COORD_W-1:0] out_cell_x,
  input wire logic [mdfs_pkg::COORD_W-1:0] out_cell_y,
  input wire logic                    out_last
);

  import mdfs_pkg::*;

  // Only a move or finished word closes the answer to an input word
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == ((out_action == ACT_MOVE) || (out_action == ACT_FINISH))))
    else $error("out_last does not match the action kind");

  // A taken word keeps the block busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // Mark and turn words are never the end of a sequence, so busy stays up
  a_mid_words_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_action == ACT_MARK) || (out_action == ACT_TURN))) |-> busy)
    else $error("mark or turn word while idle");

  // Reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind maze_dfs_explorer mdfs_checker u_mdfs_checker (.*);

`default_nettype wire

### tb/sv/maze_dfs_explorer_chk.sv
// ============================================================================
// maze_dfs_explorer_chk: command checker for the depth-first maze explorer
// Watches the report and command channels. Keeps its own copy of the robot's
// position, heading, visited map and frame stack, plans the commands that each
// accepted report word calls for, and compares every strobed command word
// field by field with the oldest planned one. Mismatches are counted.
// ============================================================================
`timescale 1ns / 1ps

module maze_dfs_explorer_chk (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic             in_command,
  input  wire logic             in_move_ok,
  input  wire logic             in_wall_front,
  input  wire logic             in_wall_right,
  input  wire logic             in_wall_left,
  input  wire logic             out_valid,
  input  wire logic [1:0]       out_action,
  input  wire mdfs_pkg::coord_t out_cell_x,
  input  wire mdfs_pkg::coord_t out_cell_y,
  input  wire logic             out_last,
  output int                    mismatches,
  output int                    cmds_due
);

  import mdfs_pkg::*;

  localparam int MAX_REPORTS = 100;

  typedef struct {
    action_t act;
    coord_t  x;
    coord_t  y;
    logic    last;
  } robot_cmd_t;

  // Commands planned but not yet seen on the output
  robot_cmd_t planned_cmds[$];

  // Robot state as the checker sees it
  coord_t     cur_x;
  coord_t     cur_y;
  dir_t       facing;
  bit         cell_seen [CELLS];
  dir_t       fr_entry [STACK_DEPTH];
  logic [2:0] fr_next [STACK_DEPTH];
  logic [3:0] fr_walls [STACK_DEPTH];
  int         depth;
  pend_t      awaiting;

  function automatic void clear_robot();
    cur_x    = '0;
    cur_y    = '0;
    facing   = DIR_RIGHT;
    depth    = 0;
    awaiting = PK_IDLE;
    foreach (cell_seen[i]) cell_seen[i] = 1'b0;
  endfunction

  function automatic int cell_of(coord_t x, coord_t y);
    return int'(y) * GRID_SIZE + int'(x);
  endfunction

  function automatic void plan(action_t a);
    robot_cmd_t c;
    c.act  = a;
    c.x    = cur_x;
    c.y    = cur_y;
    c.last = 1'b0;
    planned_cmds.push_back(c);
  endfunction

  // Neighbour one step away; returns 0 when it falls off the grid
  function automatic bit next_cell(dir_t d, output coord_t nx, output coord_t ny);
    int x;
    int y;
    x = int'(cur_x);
    y = int'(cur_y);
    case (d)
      DIR_RIGHT: x = x + 1;
      DIR_DOWN:  y = y + 1;
      DIR_LEFT:  x = x - 1;
      default:   y = y - 1;
    endcase
    nx = coord_t'(x);
    ny = coord_t'(y);
    return (x >= 0) && (y >= 0) && (x < GRID_SIZE) && (y < GRID_SIZE);
  endfunction

  // Right turns only
  function automatic void rotate_to(dir_t d);
    while (facing != d) begin
      plan(ACT_TURN);
      facing = dir_t'(facing + 2'd1);
    end
  endfunction

  function automatic void step_ahead();
    coord_t nx;
    coord_t ny;
    if (next_cell(facing, nx, ny)) begin
      cur_x = nx;
      cur_y = ny;
    end
  endfunction

  // Scan the top frame for an open, on-grid, unvisited direction; else retreat
  function automatic void scan_top();
    int     top;
    dir_t   d;
    coord_t nx;
    coord_t ny;
    bit     open;
    if (depth == 0) begin
      plan(ACT_FINISH);
      awaiting = PK_DONE;
      return;
    end
    top = depth - 1;
    while (fr_next[top] < 3'd4) begin
      d = dir_t'(fr_next[top]);
      fr_next[top] = fr_next[top] + 3'd1;
      open = !fr_walls[top][d];
      if (open) open = next_cell(d, nx, ny);
      if (open) open = !cell_seen[cell_of(nx, ny)];
      if (open) begin
        rotate_to(d);
        plan(ACT_MOVE);
        awaiting = PK_EXPLORE;
        return;
      end
    end
    // back at the root with nothing left: exploration is over
    if (depth == 1) begin
      plan(ACT_FINISH);
      awaiting = PK_DONE;
      return;
    end
    depth = depth - 1;
    rotate_to(dir_t'(fr_entry[top] + 2'd2));
    plan(ACT_MOVE);
    awaiting = PK_BACK;
  endfunction

  // Arrival: mark; unless the cell was seen or the stack is full, store walls in absolute terms and push a frame
  function automatic void enter_cell(logic wf, logic wr, logic wl);
    int         idx;
    bit         was_seen;
    logic [3:0] w;
    idx = cell_of(cur_x, cur_y);
    was_seen = cell_seen[idx];
    cell_seen[idx] = 1'b1;
    plan(ACT_MARK);
    if (was_seen || depth >= STACK_DEPTH) begin
      rotate_to(dir_t'(facing + 2'd2));
      plan(ACT_MOVE);
      awaiting = PK_BACK;
      return;
    end
    w = '0;
    if (wf) w[facing] = 1'b1;
    if (wr) w[dir_t'(facing + 2'd1)] = 1'b1;
    if (wl) w[dir_t'(facing + 2'd3)] = 1'b1;
    fr_entry[depth] = facing;
    fr_next[depth]  = 3'd0;
    fr_walls[depth] = w;
    depth = depth + 1;
    scan_top();
  endfunction

  // All commands caused by one report word; the final one carries last
  function automatic void plan_commands(logic cmd, logic ok, logic wf, logic wr,
                                        logic wl);
    int         before_n;
    robot_cmd_t c;
    before_n = planned_cmds.size();
    if (cmd == CMD_START) begin
      clear_robot();
      enter_cell(wf, wr, wl);
    end else begin
      case (awaiting)
        PK_EXPLORE: begin
          if (ok) begin
            step_ahead();
            enter_cell(wf, wr, wl);
          end else begin
            scan_top();
          end
        end
        PK_BACK: begin
          // a failed back move still counts as arrived at the parent
          step_ahead();
          rotate_to(dir_t'(facing + 2'd2));
          scan_top();
        end
        PK_DONE: plan(ACT_FINISH);
        default: ;
      endcase
    end
    if (planned_cmds.size() > before_n) begin
      c = planned_cmds.pop_back();
      c.last = 1'b1;
      planned_cmds.push_back(c);
    end
  endfunction

  // Compare strobed commands first, then plan for a newly taken word
  always @(posedge clk) begin : watch
    robot_cmd_t want;
    if (!rst_n) begin
      clear_robot();
      planned_cmds.delete();
    end else begin
      if (out_valid) begin
        if (planned_cmds.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: unexpected word: action %0d cell (%0d,%0d) last %0b",
                     $time, out_action, out_cell_x, out_cell_y, out_last);
        end else begin
          want = planned_cmds.pop_front();
          if (out_action !== want.act || out_cell_x !== want.x ||
              out_cell_y !== want.y || out_last !== want.last) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display(
                "%0t ns: expected action %0d (%0d,%0d) last %0b, got %0d (%0d,%0d) last %0b",
                $time, want.act, want.x, want.y, want.last,
                out_action, out_cell_x, out_cell_y, out_last);
          end
        end
      end
      if (start && !busy)
        plan_commands(in_command, in_move_ok, in_wall_front, in_wall_right,
                      in_wall_left);
    end
    cmds_due = planned_cmds.size();
  end

endmodule

### tb/sv/maze_dfs_explorer_tb.sv
// ============================================================================
// maze_dfs_explorer_tb: testbench top for the depth-first maze explorer
// Drives report words through the start/busy handshake: a directed opening
// (boxed-in origin, failed forward and back moves, restarts mid-move, repeats
// after finishing), one fully open grid run to the far corner and a full
// stack, then random episodes with sparse walls plus noise and short broken
// runs. The checker beside the block predicts and compares; this top only
// makes stimulus, runs the stall watchdog and gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module maze_dfs_explorer_tb;
  import mdfs_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 500;
  localparam int OPEN_RUN     = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 24;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       start         = 1'b0;
  logic       in_command    = 1'b0;
  logic       in_move_ok    = 1'b0;
  logic       in_wall_front = 1'b0;
  logic       in_wall_right = 1'b0;
  logic       in_wall_left  = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [1:0] out_action;
  coord_t     out_cell_x;
  coord_t     out_cell_y;
  logic       out_last;

  int mismatches;
  int cmds_due;
  int words_sent  = 0;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  maze_dfs_explorer uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_move_ok    (in_move_ok),
    .in_wall_front (in_wall_front),
    .in_wall_right (in_wall_right),
    .in_wall_left  (in_wall_left),
    .out_valid     (out_valid),
    .out_action    (out_action),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_last      (out_last)
  );

  maze_dfs_explorer_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_move_ok    (in_move_ok),
    .in_wall_front (in_wall_front),
    .in_wall_right (in_wall_right),
    .in_wall_left  (in_wall_left),
    .out_valid     (out_valid),
    .out_action    (out_action),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_last      (out_last),
    .mismatches    (mismatches),
    .cmds_due      (cmds_due)
  );

  // Watchdog: too long with no word taken and no command strobed
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // One report word: optional gap, then hold until taken
  task automatic send_word(logic cmd, logic ok, logic wf, logic wr, logic wl);
    int gap;
    int pick;
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 50);
    end
    // occasionally switch to or from back-to-back words
    if ($urandom_range(0, 49) == 0) steady = !steady;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_command    <= cmd;
    in_move_ok    <= ok;
    in_wall_front <= wf;
    in_wall_right <= wr;
    in_wall_left  <= wl;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent = words_sent + 1;
  endtask

  task automatic send_report(int wall_pct, int fail_pct);
    send_word(CMD_REPORT, !chance(fail_pct), chance(wall_pct), chance(wall_pct),
              chance(wall_pct));
  endtask

  // Hold off until every planned command has been strobed
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (cmds_due != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // report before any start: ignored
    send_word(CMD_REPORT, 1'b1, 1'b1, 1'b1, 1'b1);
    // boxed in at the origin: mark, then finished
    send_word(CMD_START, 1'b0, 1'b1, 1'b1, 1'b1);
    // reports after finishing repeat the finished word
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b0, 1'b1, 1'b1, 1'b1);
    // open origin, both forward moves fail; rear and up are off the grid
    send_word(CMD_START, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b0, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b0, 1'b0, 1'b0, 1'b0);
    // two cells right, wall ahead, boxed cell below, then back out
    send_word(CMD_START, 1'b0, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b1, 1'b1, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b1, 1'b1, 1'b1, 1'b1);
    // failed back move is taken as done
    send_word(CMD_REPORT, 1'b0, 1'b1, 1'b1, 1'b1);
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b1, 1'b0);
    wait_drained();
    // restart while a forward move is pending
    send_word(CMD_START, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(CMD_START, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(CMD_REPORT, 1'b1, 1'b1, 1'b1, 1'b1);
    // restart while a back move is pending
    send_word(CMD_START, 1'b0, 1'b1, 1'b0, 1'b0);
    send_word(CMD_REPORT, 1'b1, 1'b0, 1'b1, 1'b1);
    send_word(CMD_REPORT, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic run_random();
    int kind;
    words_sent = 0;
    // open grid: snakes through every cell, so the stack fills completely
    send_word(CMD_START, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (OPEN_RUN) send_report(0, 0);
    while (words_sent < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed episode, sparse walls, few failed moves
        send_word(CMD_START, chance(50), chance(25), chance(25), chance(25));
        repeat ($urandom_range(10, 120)) send_report(25, 10);
      end else if (kind < 85) begin
        // noise: any bits, an occasional restart
        repeat ($urandom_range(4, 16))
          send_word(chance(88), chance(50), chance(50), chance(50), chance(50));
      end else begin
        // short broken run: dense walls, moves mostly failing
        send_word(CMD_START, chance(50), chance(60), chance(60), chance(60));
        repeat ($urandom_range(1, 6)) send_report(60, 60);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
design/mdfs_pkg.sv
design/mdfs_ram.sv
design/mdfs_ctrl.sv
design/mdfs_dp.sv
design/maze_dfs_explorer.sv
design/mdfs_checker.sv
tb/sv/maze_dfs_explorer_chk.sv
tb/sv/maze_dfs_explorer_tb.sv
